>>> rtl/pixel_rotation_forward_map_top_defines.svh
// Assertion macros shared by the pixel rotation forward map RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef PIXEL_ROTATION_FORWARD_MAP_TOP_DEFINES_SVH
`define PIXEL_ROTATION_FORWARD_MAP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// When ante holds, cons must hold in the same cycle.
`define PRFM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prfm same-cycle check failed");

// When ante holds, cons must hold in the following cycle.
`define PRFM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prfm next-cycle check failed");

`else

`define PRFM_ASSERT_SAME(label, ante, cons)
`define PRFM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/prfm_pkg.sv
// Shared types and constants of the pixel rotation forward map.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package prfm_pkg;

	localparam int COL_W   = 10;
	localparam int PIX_W   = 8;
	localparam int SIDE_W  = 11;
	localparam int COEF_W  = 16;
	localparam int ADDR_W  = 20;
	localparam int CFG_IDX_W = 2;

	// Offset from the center: a column minus up to 512, kept signed.
	localparam int OFS_W  = COL_W + 2;
	localparam int PROD_W = OFS_W + COEF_W;
	localparam int SUM_W  = PROD_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIDE_LENGTH = 2'd0,
		REG_COS         = 2'd1,
		REG_SIN         = 2'd2
	} cfg_reg_t;

	// Rotated but still unscaled coordinates.
	typedef struct packed {
		logic                     valid;
		logic signed [SUM_W-1:0]  sum_x;
		logic signed [SUM_W-1:0]  sum_y;
		logic [COL_W-1:0]         center;
		logic [SIDE_W-1:0]        side;
		logic [PIX_W-1:0]         pixel;
	} rot_t;

	// Destination position after rounding and the bounds check.
	typedef struct packed {
		logic               valid;
		logic               in_image;
		logic [SIDE_W-1:0]  nx;
		logic [SIDE_W-1:0]  ny;
		logic [SIDE_W-1:0]  side;
		logic [PIX_W-1:0]   pixel;
	} pos_t;

endpackage

`default_nettype wire

>>> rtl/pixel_rotation_forward_map_top.sv
// Top level of the pixel rotation forward map: configuration registers, stall control
// and the six-stage pipeline. Depends on prfm_pkg, prfm_rotate, prfm_round, prfm_addr
// and pixel_rotation_forward_map_top_defines.svh.
//
// The block maps each source pixel of a square image to its position after a rotation
// about the center (side / 2). The offset from the center is rotated by the configured
// cosine and sine, rounded half away from zero, moved back by the center and checked
// against the image; the result carries the destination column, row, linear address
// row * side + column and the pixel, with write_enable telling whether the position lies
// inside the image (the position fields are zero when it does not). One item is taken
// every clock unless the output stalls; the stages are one offset stage, one multiply
// stage with four 12 x 16 multipliers, one sum stage, two rounding and bounds stages
// and one address stage. When the output item is not taken the whole pipeline holds,
// so back-pressure reaches s_tready in the same cycle. There is no clearing pass after
// reset. Write the configuration only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_rotation_forward_map_top_defines.svh"

module pixel_rotation_forward_map_top import prfm_pkg::*; #(
	parameter int MAX_SIDE       = 1024,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COEF_W-1:0]     cfg_data,
	// Input items.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,   // src_col, src_row, pixel_value, zero pad
	// Result items.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [47:0]                m_tdata,   // dest_col, dest_row, dest_address, pixel_out
	output logic [0:0]                 m_tuser    // write_enable
);

	logic [SIDE_W-1:0]        side_q;
	logic signed [COEF_W-1:0] cos_q;
	logic signed [COEF_W-1:0] sin_q;

	logic              en;
	rot_t              rot;
	pos_t              pos;
	logic [COL_W-1:0]  dest_col, dest_row;
	logic [ADDR_W-1:0] dest_address;
	logic [PIX_W-1:0]  pixel_out;
	logic              write_enable;

	// Configuration registers; writes to an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(512);
			cos_q  <= COEF_W'(16384);
			sin_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIDE_LENGTH: side_q <= SIDE_W'(cfg_data);
				REG_COS:         cos_q  <= cfg_data;
				REG_SIN:         sin_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	// All stages move together unless the output holds an item that is not taken.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	prfm_rotate #(
		.MAX_SIDE (MAX_SIDE)
	) u_rotate (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_tvalid),
		.src_col     (s_tdata[9:0]),
		.src_row     (s_tdata[19:10]),
		.pixel_value (s_tdata[27:20]),
		.side_length (side_q),
		.cos_q       (cos_q),
		.sin_q       (sin_q),
		.rot         (rot)
	);

	prfm_round #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.rot    (rot),
		.pos    (pos)
	);

	prfm_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.pos          (pos),
		.out_valid    (m_tvalid),
		.dest_col     (dest_col),
		.dest_row     (dest_row),
		.dest_address (dest_address),
		.pixel_out    (pixel_out),
		.write_enable (write_enable)
	);

	assign m_tdata = {pixel_out, dest_address, dest_row, dest_col};
	assign m_tuser = write_enable;

	// An item outside the image carries zero position fields.
	`PRFM_ASSERT_SAME(a_outside_zero, m_tvalid && !write_enable, m_tdata[39:0] == 40'd0)
	// A stalled output also stalls the input side.
	`PRFM_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
	// An accepted item occupies the first stage on the next cycle.
	`PRFM_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, u_rotate.v_s1)

endmodule

`default_nettype wire

>>> rtl/prfm_rotate.sv
// Stages 1 to 3: center offsets, the four coefficient products and the rotation sums.
// Depends on prfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prfm_rotate import prfm_pkg::*; #(
	parameter int MAX_SIDE = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [COL_W-1:0]         src_col,
	input  wire logic [COL_W-1:0]         src_row,
	input  wire logic [PIX_W-1:0]         pixel_value,
	input  wire logic [SIDE_W-1:0]        side_length,
	input  wire logic signed [COEF_W-1:0] cos_q,
	input  wire logic signed [COEF_W-1:0] sin_q,
	output rot_t                          rot
);

	logic [SIDE_W-1:0] side_eff;
	logic [COL_W-1:0]  center;

	logic                     v_s1, v_s2, v_s3;
	logic signed [OFS_W-1:0]  dx_s1, dy_s1;
	logic [COL_W-1:0]         c_s1, c_s2, c_s3;
	logic [SIDE_W-1:0]        side_s1, side_s2, side_s3;
	logic [PIX_W-1:0]         pix_s1, pix_s2, pix_s3;
	logic signed [PROD_W-1:0] xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [SUM_W-1:0]  sx_s3, sy_s3;

	// Sides above the supported maximum saturate to it.
	assign side_eff = (32'(side_length) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : side_length;
	assign center   = side_eff[SIDE_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= $signed({2'b00, src_col}) - $signed({2'b00, center});
			dy_s1   <= $signed({2'b00, src_row}) - $signed({2'b00, center});
			c_s1    <= center;
			side_s1 <= side_eff;
			pix_s1  <= pixel_value;

			xc_s2   <= PROD_W'(dx_s1 * cos_q);
			ys_s2   <= PROD_W'(dy_s1 * sin_q);
			xs_s2   <= PROD_W'(dx_s1 * sin_q);
			yc_s2   <= PROD_W'(dy_s1 * cos_q);
			c_s2    <= c_s1;
			side_s2 <= side_s1;
			pix_s2  <= pix_s1;

			sx_s3   <= SUM_W'(xc_s2) - SUM_W'(ys_s2);
			sy_s3   <= SUM_W'(xs_s2) + SUM_W'(yc_s2);
			c_s3    <= c_s2;
			side_s3 <= side_s2;
			pix_s3  <= pix_s2;
		end
	end

	assign rot.valid  = v_s3;
	assign rot.sum_x  = sx_s3;
	assign rot.sum_y  = sy_s3;
	assign rot.center = c_s3;
	assign rot.side   = side_s3;
	assign rot.pixel  = pix_s3;

endmodule

`default_nettype wire

>>> rtl/prfm_round.sv
// Stages 4 and 5: scale down with rounding half away from zero, add the center back
// and check the bounds. Depends on prfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prfm_round import prfm_pkg::*; #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  rot_t      rot,
	output pos_t      pos
);

	localparam int RND_W = SUM_W + 1;
	localparam int Q_W   = RND_W - TRIG_FRAC_BITS;
	localparam int NX_W  = Q_W + 2;
	localparam logic [RND_W-1:0] HALF = RND_W'(1) << (TRIG_FRAC_BITS - 1);

	// Magnitude of v, plus one half, shifted down by the fraction bits.
	function automatic logic [Q_W-1:0] round_mag(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0] mag;
		logic [RND_W-1:0] sum;
		mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		sum = RND_W'(mag) + HALF;
		return Q_W'(sum >> TRIG_FRAC_BITS);
	endfunction

	logic                  v_s4, v_s5;
	logic                  negx_s4, negy_s4;
	logic [Q_W-1:0]        qx_s4, qy_s4;
	logic [COL_W-1:0]      c_s4;
	logic [SIDE_W-1:0]     side_s4, side_s5;
	logic [PIX_W-1:0]      pix_s4, pix_s5;
	logic                  in_s5;
	logic [SIDE_W-1:0]     nx_s5, ny_s5;

	logic signed [NX_W-1:0] cen, side_s, nx, ny;

	assign cen    = signed'(NX_W'(c_s4));
	assign side_s = signed'(NX_W'(side_s4));
	assign nx     = negx_s4 ? cen - signed'(NX_W'(qx_s4)) : cen + signed'(NX_W'(qx_s4));
	assign ny     = negy_s4 ? cen - signed'(NX_W'(qy_s4)) : cen + signed'(NX_W'(qy_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= rot.valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s4 <= rot.sum_x[SUM_W-1];
			negy_s4 <= rot.sum_y[SUM_W-1];
			qx_s4   <= round_mag(rot.sum_x);
			qy_s4   <= round_mag(rot.sum_y);
			c_s4    <= rot.center;
			side_s4 <= rot.side;
			pix_s4  <= rot.pixel;

			in_s5   <= !nx[NX_W-1] && (nx < side_s) && !ny[NX_W-1] && (ny < side_s);
			nx_s5   <= SIDE_W'(nx);
			ny_s5   <= SIDE_W'(ny);
			side_s5 <= side_s4;
			pix_s5  <= pix_s4;
		end
	end

	assign pos.valid    = v_s5;
	assign pos.in_image = in_s5;
	assign pos.nx       = nx_s5;
	assign pos.ny       = ny_s5;
	assign pos.side     = side_s5;
	assign pos.pixel    = pix_s5;

endmodule

`default_nettype wire

>>> rtl/prfm_addr.sv
// Stage 6: linear write address and the registered result fields.
// Depends on prfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prfm_addr import prfm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  pos_t                    pos,
	output logic                    out_valid,
	output logic [COL_W-1:0]        dest_col,
	output logic [COL_W-1:0]        dest_row,
	output logic [ADDR_W-1:0]       dest_address,
	output logic [PIX_W-1:0]        pixel_out,
	output logic                    write_enable
);

	localparam int LIN_W = 2 * SIDE_W;

	logic [LIN_W-1:0] lin;

	// The row is below the side whenever the position is inside, so this cannot overflow.
	assign lin = LIN_W'(pos.ny) * LIN_W'(pos.side) + LIN_W'(pos.nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= pos.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_out    <= pos.pixel;
			write_enable <= pos.in_image;
			if (pos.in_image) begin
				dest_col     <= COL_W'(pos.nx);
				dest_row     <= COL_W'(pos.ny);
				dest_address <= ADDR_W'(lin);
			end else begin
				dest_col     <= '0;
				dest_row     <= '0;
				dest_address <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> dv/pixel_rotation_forward_map_top_tb.sv
// Self-checking testbench for pixel_rotation_forward_map_top: a stream driver, a result
// monitor and a rotation predictor, run through several register settings and traffic mixes.
// Depends on prfm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module pixel_rotation_forward_map_top_tb;
	import prfm_pkg::*;

	localparam int MAX_SIDE        = 1024;
	localparam int TRIG_FRAC_BITS  = 14;
	localparam int PIPE_LATENCY    = 6;
	localparam int IDLE_PCT        = 61;
	localparam int BOTH_IDLE_PCT   = 29;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int CYCLE_LIMIT     = 400000;

	// The index port has one code past the register list; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct {
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] row;
		logic [PIX_W-1:0] pix;
	} src_item_t;

	typedef struct {
		logic [COL_W-1:0]  col;
		logic [COL_W-1:0]  row;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
		logic              we;
	} dest_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SIDE_LENGTH;
	logic [COEF_W-1:0]    cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [47:0]          m_tdata;
	logic [0:0]           m_tuser;

	// Copy of the block's registers, kept in step with every write.
	logic [SIDE_W-1:0]        cur_side = 11'd512;
	logic signed [COEF_W-1:0] cur_cos  = 16'sd16384;
	logic signed [COEF_W-1:0] cur_sin  = 16'sd0;

	src_item_t src_pixel_q[$];
	dest_t     expected_dest_q[$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int fail_count    = 0;
	int cycle_count   = 0;

	pixel_rotation_forward_map_top #(
		.MAX_SIDE       (MAX_SIDE),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Scales a product sum down by the fraction bits, rounding half away from zero.
	function automatic longint round_half_away(longint v);
		longint mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = (mag + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
		return (v < 0) ? -q : q;
	endfunction

	// Predicts where a source pixel lands under the current register settings.
	function automatic dest_t rotate_pixel(src_item_t it);
		dest_t  d;
		longint side;
		longint ctr;
		longint dx;
		longint dy;
		longint nx;
		longint ny;
		longint lin;
		side = longint'(cur_side);
		if (side > MAX_SIDE) begin
			side = MAX_SIDE;
		end
		ctr = side / 2;
		dx = longint'(it.col) - ctr;
		dy = longint'(it.row) - ctr;
		nx = round_half_away(dx * longint'(cur_cos) - dy * longint'(cur_sin)) + ctr;
		ny = round_half_away(dx * longint'(cur_sin) + dy * longint'(cur_cos)) + ctr;
		d.pix = it.pix;
		d.we  = (nx >= 0) && (nx < side) && (ny >= 0) && (ny < side);
		if (d.we) begin
			lin    = ny * side + nx;
			d.col  = nx[COL_W-1:0];
			d.row  = ny[COL_W-1:0];
			d.addr = lin[ADDR_W-1:0];
		end else begin
			d.col  = '0;
			d.row  = '0;
			d.addr = '0;
		end
		return d;
	endfunction

	// Driver: keeps an item on the bus until it is taken, then may pause before the next.
	always @(posedge clk) begin : driver
		src_item_t it;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it.col = s_tdata[9:0];
				it.row = s_tdata[19:10];
				it.pix = s_tdata[27:20];
				expected_dest_q.push_back(rotate_pixel(it));
			end
			if (!s_tvalid || s_tready) begin
				if (src_pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = src_pixel_q.pop_front();
					s_tdata  <= {4'b0, it.pix, it.row, it.col};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// The receiver stalls at random according to the current traffic mix.
	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: every result taken is matched against the oldest prediction.
	always @(posedge clk) begin : monitor
		dest_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_dest_q.size() == 0) begin
				$error("result item with none expected: tdata %h tuser %b", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = expected_dest_q.pop_front();
				check_field("dest_col", want.col, m_tdata[9:0]);
				check_field("dest_row", want.row, m_tdata[19:10]);
				check_field("dest_address", want.addr, m_tdata[39:20]);
				check_field("pixel_out", want.pix, m_tdata[47:40]);
				check_field("write_enable", want.we, m_tuser[0]);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_SIDE_LENGTH: cur_side = val[SIDE_W-1:0];
			REG_COS:         cur_cos  = val;
			REG_SIN:         cur_sin  = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_item(int col, int row, int pix);
		src_item_t it;
		it.col = col;
		it.row = row;
		it.pix = pix;
		src_pixel_q.push_back(it);
	endtask

	// Four traffic mixes: free flowing, sender gaps, receiver stalls, and both at once.
	task automatic set_traffic(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;             stall_pct = 0;             end
			1: begin send_idle_pct = IDLE_PCT;      stall_pct = 0;             end
			2: begin send_idle_pct = 0;             stall_pct = IDLE_PCT;      end
			default: begin send_idle_pct = BOTH_IDLE_PCT; stall_pct = BOTH_IDLE_PCT; end
		endcase
	endtask

	// Waits until every queued item has gone in and its result has come out, then lets the
	// pipeline settle so that the registers can be written safely. The input side is looked
	// at on the falling edge, where the driver's updates of the rising edge have all landed.
	task automatic drain();
		int waited;
		waited = 0;
		while (src_pixel_q.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
		while (expected_dest_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("pixel_rotation_forward_map_top regression: fail");
		$finish;
	end

	initial begin
		int lim;
		logic [COEF_W-1:0] cos_v;
		logic [COEF_W-1:0] sin_v;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: identity rotation of a 512 image. Covers the field extremes and
		// sources that sit outside the image.
		set_traffic(0);
		queue_item(0, 0, 0);
		queue_item(511, 511, 255);
		queue_item(256, 256, 8'hAA);
		queue_item(1023, 1023, 8'h55);
		queue_item(0, 1023, 1);
		queue_item(1023, 0, 254);
		queue_item(100, 200, 128);
		drain();

		// A side above the maximum saturates to it; quarter turn counterclockwise.
		set_traffic(1);
		write_reg(REG_SIDE_LENGTH, 16'd2047);
		write_reg(REG_COS, 16'd0);
		write_reg(REG_SIN, 16'd16384);
		queue_item(0, 0, 17);
		queue_item(1023, 1023, 34);
		queue_item(512, 512, 51);
		queue_item(1023, 0, 68);
		drain();

		// The unmapped index must leave the side untouched; then a zero side, where no
		// position is ever inside the image.
		set_traffic(2);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		queue_item(1023, 0, 85);
		drain();
		write_reg(REG_SIDE_LENGTH, 16'd0);
		write_reg(REG_COS, -16'sd16384);
		write_reg(REG_SIN, 16'd0);
		queue_item(0, 0, 102);
		queue_item(5, 5, 119);
		drain();

		// One-pixel image with coefficients far outside the unit range.
		set_traffic(3);
		write_reg(REG_SIDE_LENGTH, 16'd1);
		write_reg(REG_COS, 16'h7FFF);
		write_reg(REG_SIN, 16'h8000);
		queue_item(0, 0, 136);
		queue_item(1, 0, 153);
		queue_item(1023, 1023, 170);
		drain();

		// Eighth turn on the full-size image.
		set_traffic(0);
		write_reg(REG_SIDE_LENGTH, 16'd1024);
		write_reg(REG_COS, 16'd11585);
		write_reg(REG_SIN, 16'd11585);
		queue_item(512, 512, 187);
		queue_item(0, 0, 204);
		queue_item(1023, 1023, 221);
		queue_item(0, 1023, 238);
		drain();

		// Half scale on an odd side puts coordinates exactly halfway between pixels, so the
		// rounding direction shows on both signs.
		write_reg(REG_SIDE_LENGTH, 16'd7);
		write_reg(REG_COS, 16'd8192);
		write_reg(REG_SIN, 16'd0);
		queue_item(0, 0, 9);
		queue_item(6, 6, 10);
		queue_item(6, 0, 11);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_traffic(p);
			case ($urandom_range(7))
				0: write_reg(REG_SIDE_LENGTH, $urandom_range(2047));
				1: write_reg(REG_SIDE_LENGTH, 1 + $urandom_range(15));
				default: write_reg(REG_SIDE_LENGTH, 1 + $urandom_range(MAX_SIDE - 1));
			endcase
			case ($urandom_range(3))
				0: begin
					cos_v = $urandom_range(16'hFFFF);
					sin_v = $urandom_range(16'hFFFF);
				end
				1: begin
					cos_v = $urandom_range(32768) - 16384;
					sin_v = $urandom_range(32768) - 16384;
				end
				default: begin
					// Proper rotations keep most pixels inside the image.
					case ($urandom_range(7))
						0: begin cos_v = 16384;  sin_v = 0;      end
						1: begin cos_v = 0;      sin_v = 16384;  end
						2: begin cos_v = -16384; sin_v = 0;      end
						3: begin cos_v = 0;      sin_v = -16384; end
						4: begin cos_v = 11585;  sin_v = -11585; end
						5: begin cos_v = -11585; sin_v = 11585;  end
						6: begin cos_v = 14189;  sin_v = 8192;   end
						default: begin cos_v = 8192; sin_v = -14189; end
					endcase
				end
			endcase
			write_reg(REG_COS, cos_v);
			write_reg(REG_SIN, sin_v);
			if ($urandom_range(3) == 0) begin
				write_reg(REG_UNMAPPED, $urandom_range(16'hFFFF));
			end
			lim = (cur_side > MAX_SIDE) ? MAX_SIDE : cur_side;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (lim == 0 || $urandom_range(7) == 0) begin
					queue_item($urandom_range(1023), $urandom_range(1023), $urandom_range(255));
				end else begin
					queue_item($urandom_range(lim - 1), $urandom_range(lim - 1),
						$urandom_range(255));
				end
			end
			drain();
		end

		if (expected_dest_q.size() != 0) begin
			$error("%0d predicted results never arrived", expected_dest_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("pixel_rotation_forward_map_top regression: pass");
		end else begin
			$display("pixel_rotation_forward_map_top regression: fail");
		end
		$finish;
	end

endmodule
